@@ design/bfa_pkg.sv @@
// ============================================================================
// bfa_pkg
// Shared types and codes of the bitmap frame allocator: operation codes,
// status codes, register indexes and the request / result words.
// ============================================================================
`default_nettype none

package bfa_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_MARK  = 2'd1;
    localparam logic [1:0] FN_FREE  = 2'd2;

    // Status codes returned with every result
    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE     = 2'd1;
    localparam logic [1:0] STAT_OUT_OF_RANGE = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam logic [0:0] CFG_RANGE_BEGIN = 1'b0;
    localparam logic [0:0] CFG_RANGE_END   = 1'b1;

    // Register reset values
    localparam logic [15:0] RANGE_BEGIN_RST = 16'd0;
    localparam logic [15:0] RANGE_END_RST   = 16'd32768;

    // Frames examined per scan cycle
    localparam int CHUNK_BITS = 8;

    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] start_frame;
        logic [15:0] frame_count;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] first_frame;
    } t_result;

endpackage

`default_nettype wire

@@ design/bfa_mem.sv @@
// ============================================================================
// bfa_mem
// Bitmap store: one write port and one read port, read data registered and
// valid in the cycle after the read. Contents are undefined until written.
// ============================================================================
`default_nettype none

module bfa_mem #(
    parameter int WORDS = 512,
    parameter int WIDTH = 64,
    parameter int AW    = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [WORDS];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/bfa_ctrl.sv @@
// ============================================================================
// bfa_ctrl
// Request sequencer: clears the bitmap after reset, scans for a first-fit
// free run eight frames a cycle, and sets or clears a run one word a cycle
// by read-modify-write.
// ============================================================================
`default_nettype none

module bfa_ctrl #(
    parameter int FRAME_COUNT = 32768,
    parameter int WORD_BITS   = 64,
    parameter int MAP_WORDS   = FRAME_COUNT / WORD_BITS,
    parameter int AW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_we,
    input  wire logic [bfa_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [15:0]                  i_cfg_wdata,
    // requests
    input  wire logic                         i_req_valid,
    output logic                              o_req_ready,
    input  wire bfa_pkg::t_request            i_req,
    // results
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output bfa_pkg::t_result                  o_res,
    // bitmap store
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic [WORD_BITS-1:0]              o_wr_data,
    output logic                              o_rd_en,
    output logic [AW-1:0]                     o_rd_addr,
    input  wire logic [WORD_BITS-1:0]         i_rd_data
);

    localparam int BW     = $clog2(WORD_BITS);
    localparam int FAW    = AW + BW;
    localparam int FCW    = $clog2(FRAME_COUNT) + 2;
    localparam int VW     = (FCW > 18) ? FCW : 18;
    localparam int NCHUNK = WORD_BITS / bfa_pkg::CHUNK_BITS;
    localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CBW    = $clog2(bfa_pkg::CHUNK_BITS);

    localparam logic [VW-1:0]  FC_V     = VW'(FRAME_COUNT);
    localparam logic [AW-1:0]  LAST_W   = AW'(MAP_WORDS - 1);
    localparam logic [CKW-1:0] LAST_CK  = CKW'(NCHUNK - 1);
    localparam logic [BW-1:0]  TOP_BIT  = BW'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WR_RD,
        S_WR,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_wa, n_wa;
    logic [CKW-1:0]   r_chunk, n_chunk;
    logic [VW-1:0]    r_run, n_run;
    logic [VW-1:0]    r_s, n_s;
    logic [VW-1:0]    r_count, n_count;
    logic             r_used, n_used;
    logic             r_alloc, n_alloc;
    logic [1:0]       r_status, n_status;
    logic [14:0]      r_first, n_first;
    logic [15:0]      r_begin, r_end;

    logic [VW-1:0]    begin_v, end_v, end_eff;
    logic [VW-1:0]    req_start_v, req_count_v;
    logic [VW-1:0]    hi_v;
    logic [AW-1:0]    s_word, hi_word;

    // scan of one chunk
    logic [VW-1:0]    sc_base, sc_run, sc_s, sc_fidx;
    logic [bfa_pkg::CHUNK_BITS-1:0] sc_bits;
    logic             sc_found, sc_free, sc_last;

    // run mask for one word
    logic [BW-1:0]    lo_bit, hi_bit;
    logic [WORD_BITS-1:0] run_mask;

    // Effective allocate window and request operands
    always_comb begin
        begin_v     = VW'(r_begin);
        end_v       = VW'(r_end);
        end_eff     = (end_v > FC_V) ? FC_V : end_v;
        req_start_v = VW'(i_req.start_frame);
        req_count_v = VW'(i_req.frame_count);
        hi_v        = r_s + r_count - VW'(1);
        s_word      = r_s[FAW-1:BW];
        hi_word     = hi_v[FAW-1:BW];
    end

    // Walk the eight frames of the current chunk for a long enough free run
    always_comb begin
        sc_base  = (VW'(r_wa) << BW) + (VW'(r_chunk) << CBW);
        sc_bits  = i_rd_data[bfa_pkg::CHUNK_BITS*r_chunk +: bfa_pkg::CHUNK_BITS];
        sc_run   = r_run;
        sc_s     = r_s;
        sc_found = 1'b0;
        sc_fidx  = sc_base;
        sc_free  = 1'b0;
        for (int j = 0; j < bfa_pkg::CHUNK_BITS; j++) begin
            sc_fidx = sc_base + VW'(j);
            sc_free = !sc_bits[j] && (sc_fidx >= begin_v) && (sc_fidx < end_eff);
            if (!sc_found) begin
                if (!sc_free) begin
                    sc_run = '0;
                    sc_s   = sc_fidx + VW'(1);
                end else begin
                    sc_run = sc_run + VW'(1);
                    if (sc_run == r_count) begin
                        sc_found = 1'b1;
                    end
                end
            end
        end
        sc_last = (sc_base + VW'(bfa_pkg::CHUNK_BITS)) >= end_eff;
    end

    // Bits of the run that fall in the current word
    always_comb begin
        lo_bit   = (r_wa == s_word)  ? r_s[BW-1:0]  : '0;
        hi_bit   = (r_wa == hi_word) ? hi_v[BW-1:0] : TOP_BIT;
        run_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (TOP_BIT - hi_bit));
    end

    // Next-state and store access
    always_comb begin
        n_state   = r_state;
        n_wa      = r_wa;
        n_chunk   = r_chunk;
        n_run     = r_run;
        n_s       = r_s;
        n_count   = r_count;
        n_used    = r_used;
        n_alloc   = r_alloc;
        n_status  = r_status;
        n_first   = r_first;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wa;
        o_wr_data = '0;
        o_rd_en   = 1'b0;
        o_rd_addr = r_wa;

        case (r_state)
            S_CLEAR: begin
                o_wr_en = 1'b1;
                if (r_wa == LAST_W) begin
                    n_wa    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_wa = r_wa + AW'(1);
                end
            end

            S_IDLE: begin
                if (i_req_valid) begin
                    n_status = bfa_pkg::STAT_OK;
                    n_first  = '0;
                    n_count  = req_count_v;
                    n_state  = S_DONE;
                    case (i_req.func)
                        bfa_pkg::FN_ALLOC: begin
                            if (req_count_v > FC_V) begin
                                n_status = bfa_pkg::STAT_OUT_OF_RANGE;
                            end else if (req_count_v == '0) begin
                                n_status = bfa_pkg::STAT_OK;
                            end else if (begin_v >= end_eff) begin
                                n_status = bfa_pkg::STAT_NO_SPACE;
                            end else begin
                                n_wa      = begin_v[FAW-1:BW];
                                n_chunk   = CKW'((begin_v >> CBW) % NCHUNK);
                                n_run     = '0;
                                n_s       = begin_v;
                                o_rd_en   = 1'b1;
                                o_rd_addr = begin_v[FAW-1:BW];
                                n_state   = S_SCAN;
                            end
                        end
                        bfa_pkg::FN_MARK, bfa_pkg::FN_FREE: begin
                            if ((req_start_v + req_count_v) > FC_V) begin
                                n_status = bfa_pkg::STAT_OUT_OF_RANGE;
                            end else if (req_count_v != '0) begin
                                n_s     = req_start_v;
                                n_wa    = req_start_v[FAW-1:BW];
                                n_used  = (i_req.func == bfa_pkg::FN_MARK);
                                n_alloc = 1'b0;
                                n_state = S_WR_RD;
                            end
                        end
                        default: begin
                            n_status = bfa_pkg::STAT_OUT_OF_RANGE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (sc_found) begin
                    n_s     = sc_s;
                    n_wa    = sc_s[FAW-1:BW];
                    n_used  = 1'b1;
                    n_alloc = 1'b1;
                    n_state = S_WR_RD;
                end else if (sc_last) begin
                    n_status = bfa_pkg::STAT_NO_SPACE;
                    n_first  = '0;
                    n_state  = S_DONE;
                end else begin
                    n_run = sc_run;
                    n_s   = sc_s;
                    if (r_chunk == LAST_CK) begin
                        // next word arrives with the next cycle
                        n_chunk   = '0;
                        n_wa      = r_wa + AW'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_wa + AW'(1);
                    end else begin
                        n_chunk = r_chunk + CKW'(1);
                    end
                end
            end

            S_WR_RD: begin
                o_rd_en = 1'b1;
                n_state = S_WR;
            end

            S_WR: begin
                o_wr_en   = 1'b1;
                o_wr_data = r_used ? (i_rd_data | run_mask) : (i_rd_data & ~run_mask);
                if (r_wa == hi_word) begin
                    n_status = bfa_pkg::STAT_OK;
                    n_first  = r_alloc ? r_s[14:0] : 15'd0;
                    n_state  = S_DONE;
                end else begin
                    // fetch the following word while this one is written
                    n_wa      = r_wa + AW'(1);
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_wa + AW'(1);
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.first_frame = r_first;

    // State, configuration and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_wa    <= '0;
            r_begin <= bfa_pkg::RANGE_BEGIN_RST;
            r_end   <= bfa_pkg::RANGE_END_RST;
        end else begin
            r_state <= n_state;
            r_wa    <= n_wa;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bfa_pkg::CFG_RANGE_BEGIN: r_begin <= i_cfg_wdata;
                    bfa_pkg::CFG_RANGE_END:   r_end   <= i_cfg_wdata;
                    default: begin
                        r_begin <= r_begin;
                    end
                endcase
            end
        end
        r_chunk  <= n_chunk;
        r_run    <= n_run;
        r_s      <= n_s;
        r_count  <= n_count;
        r_used   <= n_used;
        r_alloc  <= n_alloc;
        r_status <= n_status;
        r_first  <= n_first;
    end

endmodule

`default_nettype wire

@@ design/bitmap_frame_allocator_top.sv @@
// ============================================================================
// bitmap_frame_allocator_top
// First-fit page frame allocator over a used/free bitmap held in one memory.
// ============================================================================
// After reset the bitmap is swept to all-free, one word a cycle, and
// s_axis_tready stays low meanwhile; configuration writes are taken. One
// request is worked at a time. Mark and free read and rewrite, one after
// another, each bitmap word the run touches. Allocate scans from range_begin
// eight frames a cycle up to the chunk that completes the run, then marks the
// run the same way; a failed scan returns no-space at the end of the window.
// Rejected, empty-window and zero-length requests skip the bitmap and go
// straight to the result. The result word sits in an output register, so a
// new request is taken while it waits.
// ============================================================================
`default_nettype none

module bitmap_frame_allocator_top #(
    parameter int FRAME_COUNT = 32768,
    parameter int WORD_BITS   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [14:0] start_frame, [30:15] frame_count, [31] 0
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [1:0] status, [16:2] first_frame, [23:17] 0
);

    localparam int MAP_WORDS = FRAME_COUNT / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    bfa_pkg::t_request req;
    bfa_pkg::t_result  res;
    logic              res_valid, res_ready;
    logic              r_out_valid;
    bfa_pkg::t_result  r_out;

    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [WORD_BITS-1:0] wr_data, rd_data;

    // Unpack the request word
    assign req.func        = s_axis_tuser;
    assign req.start_frame = s_axis_tdata[14:0];
    assign req.frame_count = s_axis_tdata[30:15];

    bfa_ctrl #(
        .FRAME_COUNT (FRAME_COUNT),
        .WORD_BITS   (WORD_BITS),
        .MAP_WORDS   (MAP_WORDS),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    bfa_mem #(
        .WORDS (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: take a new result when empty or being drained
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.first_frame, r_out.status};

endmodule

`default_nettype wire

@@ design/bfa_checker.sv @@
// ============================================================================
// bfa_checker
// Port-level checks of the bitmap frame allocator, bound to the top level.
// ============================================================================
`default_nettype none

module bfa_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata
);

    // Clearing pass blocks requests right after reset
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during bitmap clear");

    // One request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while one is in work");

    // A nonzero first frame only comes with a successful allocate
    a_first_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[16:2] != 15'd0))
            |-> (m_axis_tdata[1:0] == bfa_pkg::STAT_OK))
        else $error("first frame reported with a failing status");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
